// ----- hdl/tatu_pkg.sv -----
// Package for the thermistor ADC to temperature unit.
// Holds the shared widths, constants, codes and the pipeline tag type.
// No dependencies.
`default_nettype none

package tatu_pkg;

    localparam int ADC_FULL_SCALE = 1024;
    localparam int ADC_W          = 10;

    localparam int LOG_IN_W  = 24;
    localparam int LOG_E_W   = 5;
    localparam int LOG_F_W   = 16;
    localparam int LOG_W     = LOG_E_W + LOG_F_W;
    localparam int LOG_LANES = 4;
    localparam int LOG_STEPS = LOG_F_W;

    localparam int DIV_W = 48;

    localparam logic [DIV_W-1:0] INV_NUM = 48'd100 << 40;
    localparam logic [16:0]      LN2_Q16 = 17'd45426;
    localparam logic [23:0]      RECIP5  = 24'd13421773;
    localparam int               RECIP5_SHIFT = 26;

    localparam int T_W = 19;
    localparam logic signed [T_W-1:0] OUT_MAX = 19'sd200000;
    localparam logic signed [T_W-1:0] OUT_MIN = -19'sd100000;

    localparam logic [1:0] UNIT_K = 2'd0;
    localparam logic [1:0] UNIT_C = 2'd1;
    localparam logic [1:0] UNIT_F = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic [2:0] CFG_BETA    = 3'd0;
    localparam logic [2:0] CFG_T0      = 3'd1;
    localparam logic [2:0] CFG_R0      = 3'd2;
    localparam logic [2:0] CFG_BALANCE = 3'd3;
    localparam logic [2:0] CFG_UNIT    = 3'd4;

    typedef struct packed {
        logic valid;
        logic zero_err;
        logic sat_err;
        logic neg;
    } tatu_tag_t;

endpackage

`default_nettype wire

// ----- hdl/thermistor_adc_to_temperature_unit.sv -----
// Thermistor ADC sample to temperature, B-parameter equation in fixed point.
// Pipeline: log stages 17, three pipelined 48-bit dividers of 48 stages each (two side by
// side, the third after them), 9 more.
// Throughput: one item per cycle; a stalled output freezes every stage.
// Reset clears all valid bits and loads the default configuration.
// Depends on tatu_pkg, tatu_log4, tatu_div and tatu_conv.
`default_nettype none

module thermistor_adc_to_temperature_unit import tatu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [9:0] adc_sample
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [18:0] temperature_centi, [20:19] status
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    logic [15:0] beta_reg;
    logic [15:0] t0_reg;
    logic [23:0] r0_reg;
    logic [23:0] balance_reg;
    logic [1:0]  unit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta_reg    <= 16'd4300;
            t0_reg      <= 16'd29815;
            r0_reg      <= 24'd10000;
            balance_reg <= 24'd10000;
            unit_reg    <= UNIT_C;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_BETA:    beta_reg    <= cfg_data[15:0];
                CFG_T0:      t0_reg      <= cfg_data[15:0];
                CFG_R0:      r0_reg      <= cfg_data;
                CFG_BALANCE: balance_reg <= cfg_data;
                CFG_UNIT:    unit_reg    <= cfg_data[1:0];
                default:     ;
            endcase
        end
    end

    logic en;
    logic accept;
    logic [ADC_W-1:0] sample;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && s_tready;
    assign sample   = s_tdata[ADC_W-1:0];

    // Entry stage.
    tatu_tag_t            ent_tag_reg;
    logic [LOG_IN_W-1:0]  ent_x_reg [LOG_LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_tag_reg <= '0;
        end
        else if (en)
        begin
            ent_tag_reg.valid    <= accept;
            ent_tag_reg.zero_err <= sample == '0;
            ent_tag_reg.sat_err  <= 32'(sample) >= 32'(ADC_FULL_SCALE) || balance_reg == '0;
            ent_tag_reg.neg      <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ent_x_reg[0] <= balance_reg;
            ent_x_reg[1] <= LOG_IN_W'(ADC_FULL_SCALE) - LOG_IN_W'(sample);
            ent_x_reg[2] <= LOG_IN_W'(sample);
            ent_x_reg[3] <= (r0_reg == '0) ? 24'd1 : r0_reg;
        end
    end

    tatu_tag_t        log_tag;
    logic [LOG_W-1:0] lg [LOG_LANES];

    tatu_log4 u_log
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_tag  (ent_tag_reg),
        .x       (ent_x_reg),
        .out_tag (log_tag),
        .lg      (lg)
    );

    // Sum of logarithms, ln scaling and magnitude split.
    tatu_tag_t          sum_tag_reg, mul_tag_reg, prep_tag_reg;
    logic signed [22:0] l2_reg;
    logic signed [39:0] ln_reg;
    logic [DIV_W-1:0]   num2_reg;
    logic [38:0]        ln_mag;

    assign ln_mag = ln_reg[39] ? 39'(-ln_reg) : 39'(ln_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_tag_reg  <= '0;
            mul_tag_reg  <= '0;
            prep_tag_reg <= '0;
        end
        else if (en)
        begin
            sum_tag_reg  <= log_tag;
            mul_tag_reg  <= sum_tag_reg;
            prep_tag_reg <= '{valid:    mul_tag_reg.valid,
                              zero_err: mul_tag_reg.zero_err,
                              sat_err:  mul_tag_reg.sat_err,
                              neg:      ln_reg[39]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l2_reg   <= $signed({2'b00, lg[0]}) + $signed({2'b00, lg[1]})
                      - $signed({2'b00, lg[2]}) - $signed({2'b00, lg[3]});
            ln_reg   <= 40'(l2_reg * $signed(LN2_Q16));
            num2_reg <= DIV_W'(ln_mag) << 8;
        end
    end

    tatu_tag_t        d1_tag, d2_tag, d3_tag;
    logic [DIV_W-1:0] q1, q2, q3;
    logic [DIV_W-1:0] t0_den, b_den;

    assign t0_den = DIV_W'((t0_reg == '0) ? 16'd1 : t0_reg);
    assign b_den  = DIV_W'((beta_reg == '0) ? 16'd1 : beta_reg);

    tatu_div u_div_t0
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_tag  (prep_tag_reg),
        .num     (INV_NUM),
        .den     (t0_den),
        .out_tag (d1_tag),
        .quo     (q1)
    );

    tatu_div u_div_beta
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_tag  (prep_tag_reg),
        .num     (num2_reg),
        .den     (b_den),
        .out_tag (d2_tag),
        .quo     (q2)
    );

    // Inverse temperature and setup of the final reciprocal.
    logic signed [49:0] inv;
    logic               inv_bad;
    tatu_tag_t          inv_tag_reg, n3_tag_reg;
    logic [DIV_W-1:0]   inv_reg;
    logic [DIV_W-1:0]   num3_reg, den3_reg;

    always_comb
    begin
        inv = $signed({2'b00, q1}) + (d2_tag.neg ? -$signed({2'b00, q2})
                                                 : $signed({2'b00, q2}));
        inv_bad = inv <= 0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_tag_reg <= '0;
            n3_tag_reg  <= '0;
        end
        else if (en)
        begin
            inv_tag_reg.valid    <= d1_tag.valid;
            inv_tag_reg.zero_err <= d1_tag.zero_err;
            inv_tag_reg.sat_err  <= d1_tag.sat_err || inv_bad;
            inv_tag_reg.neg      <= 1'b0;
            n3_tag_reg           <= inv_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inv_reg  <= inv_bad ? DIV_W'(1) : inv[DIV_W-1:0];
            num3_reg <= INV_NUM + (inv_reg >> 1);
            den3_reg <= inv_reg;
        end
    end

    tatu_div u_div_inv
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_tag  (n3_tag_reg),
        .num     (num3_reg),
        .den     (den3_reg),
        .out_tag (d3_tag),
        .quo     (q3)
    );

    logic signed [T_W-1:0] temp;
    logic [1:0]            status;

    tatu_conv u_conv
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_tag    (d3_tag),
        .tk        (q3),
        .unit      (unit_reg),
        .out_valid (m_tvalid),
        .temp      (temp),
        .status    (status)
    );

    assign m_tdata = {3'b000, status, temp};

endmodule

`default_nettype wire

// ----- hdl/tatu_log4.sv -----
// Four-lane pipelined base-2 logarithm in Q16, one squaring per stage.
// Depends on tatu_pkg.
`default_nettype none

module tatu_log4 import tatu_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  tatu_tag_t                in_tag,
    input  wire logic [LOG_IN_W-1:0] x [LOG_LANES],
    output tatu_tag_t                out_tag,
    output logic      [LOG_W-1:0]    lg [LOG_LANES]
);

    tatu_tag_t            tag_reg [LOG_STEPS+1];
    logic [31:0]          m_reg   [LOG_STEPS+1][LOG_LANES];
    logic [LOG_E_W-1:0]   e_reg   [LOG_STEPS+1][LOG_LANES];
    logic [LOG_F_W-1:0]   f_reg   [LOG_STEPS+1][LOG_LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg[0] <= '0;
        end
        else if (en)
        begin
            tag_reg[0] <= in_tag;
        end
    end

    for (genvar l = 0; l < LOG_LANES; l++)
    begin : g_norm
        logic [LOG_E_W-1:0] e_next;
        logic [31:0]        m_next;

        always_comb
        begin
            e_next = '0;
            for (int b = 0; b < LOG_IN_W; b++)
            begin
                if (x[l][b])
                begin
                    e_next = LOG_E_W'(b);
                end
            end
            m_next = 32'(x[l]) << (5'd31 - e_next);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[0][l] <= m_next;
                e_reg[0][l] <= e_next;
                f_reg[0][l] <= '0;
            end
        end
    end

    for (genvar k = 0; k < LOG_STEPS; k++)
    begin : g_step
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[k+1] <= '0;
            end
            else if (en)
            begin
                tag_reg[k+1] <= tag_reg[k];
            end
        end

        for (genvar l = 0; l < LOG_LANES; l++)
        begin : g_lane
            logic [63:0] prod;
            logic [32:0] sq;

            always_comb
            begin
                prod = m_reg[k][l] * m_reg[k][l];
                sq   = prod[63:31];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    m_reg[k+1][l] <= sq[32] ? sq[32:1] : sq[31:0];
                    e_reg[k+1][l] <= e_reg[k][l];
                    f_reg[k+1][l] <= {f_reg[k][l][LOG_F_W-2:0], sq[32]};
                end
            end
        end
    end

    assign out_tag = tag_reg[LOG_STEPS];

    for (genvar l = 0; l < LOG_LANES; l++)
    begin : g_out
        assign lg[l] = {e_reg[LOG_STEPS][l], f_reg[LOG_STEPS][l]};
    end

endmodule

`default_nettype wire

// ----- hdl/tatu_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Depends on tatu_pkg.
`default_nettype none

module tatu_div import tatu_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  tatu_tag_t             in_tag,
    input  wire logic [DIV_W-1:0] num,
    input  wire logic [DIV_W-1:0] den,
    output tatu_tag_t             out_tag,
    output logic      [DIV_W-1:0] quo
);

    tatu_tag_t        tag_reg [DIV_W];
    logic [DIV_W-1:0] rem_reg [DIV_W];
    logic [DIV_W-1:0] nq_reg  [DIV_W];
    logic [DIV_W-1:0] den_reg [DIV_W];

    for (genvar k = 0; k < DIV_W; k++)
    begin : g_stage
        tatu_tag_t        tag_in;
        logic [DIV_W-1:0] rem_in;
        logic [DIV_W-1:0] nq_in;
        logic [DIV_W-1:0] den_in;
        logic [DIV_W:0]   trial;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign tag_in = in_tag;
            assign rem_in = '0;
            assign nq_in  = num;
            assign den_in = den;
        end
        else
        begin : g_next
            assign tag_in = tag_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign nq_in  = nq_reg[k-1];
            assign den_in = den_reg[k-1];
        end

        always_comb
        begin
            trial = {rem_in, nq_in[DIV_W-1]};
            ge    = trial >= {1'b0, den_in};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[k] <= '0;
            end
            else if (en)
            begin
                tag_reg[k] <= tag_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? DIV_W'(trial - {1'b0, den_in}) : trial[DIV_W-1:0];
                nq_reg[k]  <= {nq_in[DIV_W-2:0], ge};
                den_reg[k] <= den_in;
            end
        end
    end

    assign out_tag = tag_reg[DIV_W-1];
    assign quo     = nq_reg[DIV_W-1];

endmodule

`default_nettype wire

// ----- hdl/tatu_conv.sv -----
// Unit conversion, saturation and output register of the temperature unit.
// Depends on tatu_pkg.
`default_nettype none

module tatu_conv import tatu_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  tatu_tag_t             in_tag,
    input  wire logic [DIV_W-1:0] tk,
    input  wire logic [1:0]       unit,
    output logic                  out_valid,
    output logic signed [T_W-1:0] temp,
    output logic [1:0]            status
);

    tatu_tag_t           tag1_reg, tag2_reg;
    logic                big1_reg, big2_reg;
    logic [19:0]         tk1_reg, tk2_reg;
    logic signed [21:0]  c1_reg, c2_reg;
    logic                neg1_reg, neg2_reg;
    logic [23:0]         av1_reg;
    logic [21:0]         q2_reg;

    logic signed [21:0]  c_next;
    logic signed [25:0]  v_next;
    logic [25:0]         av_next;
    logic [47:0]         prod;
    logic signed [22:0]  f_val;
    logic signed [22:0]  t_val;
    logic                out_valid_next;
    logic signed [T_W-1:0] temp_next;
    logic [1:0]          status_next;

    always_comb
    begin
        c_next  = $signed({2'b00, tk[19:0]}) - 22'sd27315;
        v_next  = 26'(c_next) * 26'sd9;
        av_next = (v_next < 0) ? 26'(-v_next) : 26'(v_next);
        prod    = av1_reg * RECIP5;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg  <= '0;
            tag2_reg  <= '0;
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            tag1_reg  <= in_tag;
            tag2_reg  <= tag1_reg;
            out_valid <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            big1_reg <= |tk[DIV_W-1:20];
            tk1_reg  <= tk[19:0];
            c1_reg   <= c_next;
            neg1_reg <= v_next < 0;
            av1_reg  <= 24'(av_next + 26'd2);
            big2_reg <= big1_reg;
            tk2_reg  <= tk1_reg;
            c2_reg   <= c1_reg;
            neg2_reg <= neg1_reg;
            q2_reg   <= prod[47:RECIP5_SHIFT];
            temp     <= temp_next;
            status   <= status_next;
        end
    end

    always_comb
    begin
        f_val = neg2_reg ? 23'sd3200 - $signed({1'b0, q2_reg})
                         : 23'sd3200 + $signed({1'b0, q2_reg});
        case (unit)
            UNIT_C:  t_val = 23'(c2_reg);
            UNIT_F:  t_val = f_val;
            default: t_val = $signed({3'b000, tk2_reg});
        endcase
        out_valid_next = tag2_reg.valid;
        if (tag2_reg.zero_err)
        begin
            temp_next   = OUT_MAX;
            status_next = ST_ZERO;
        end
        else if (tag2_reg.sat_err || big2_reg || t_val > 23'(OUT_MAX))
        begin
            temp_next   = OUT_MAX;
            status_next = ST_SAT;
        end
        else if (t_val < 23'(OUT_MIN))
        begin
            temp_next   = OUT_MIN;
            status_next = ST_SAT;
        end
        else
        begin
            temp_next   = T_W'(t_val);
            status_next = ST_OK;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/tatu_chk.sv -----
// Port-level checker for the thermistor ADC to temperature unit, with its bind.
// Depends on tatu_pkg.
`default_nettype none

module tatu_chk import tatu_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    logic signed [T_W-1:0] temp;
    logic [1:0]            status;

    assign temp   = m_tdata[T_W-1:0];
    assign status = m_tdata[20:19];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output item changed while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && status == ST_ZERO |-> temp == OUT_MAX)
        else $error("zero sample item without saturated maximum");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> status == ST_OK || status == ST_ZERO || status == ST_SAT)
        else $error("unknown status code");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> temp <= OUT_MAX && temp >= OUT_MIN)
        else $error("temperature outside output range");

endmodule

bind thermistor_adc_to_temperature_unit tatu_chk u_tatu_chk
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- tb/tb_thermistor_adc_to_temperature_unit.sv -----
// Testbench for the thermistor ADC to temperature unit: drives converter samples
// through the stream port, predicts each temperature in fixed point and checks it.
// Depends on tatu_pkg and thermistor_adc_to_temperature_unit.
`timescale 1ns / 1ps

module tb_thermistor_adc_to_temperature_unit;
    import tatu_pkg::*;

    localparam int LATENCY = 122;

    typedef struct packed {
        logic signed [18:0] temp;
        logic [1:0]         status;
    } temp_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;

    logic [15:0] beta_reg;
    logic [15:0] t0_reg;
    logic [23:0] r0_reg;
    logic [23:0] balance_reg;
    logic [1:0]  unit_reg;

    logic [9:0]   sample_queue[$];
    temp_result_t expected_temps[$];
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_off_cycles;
    logic         hold_off_req;
    logic         hold_off_done;
    logic         in_taken;
    int           mismatch_count = 0;

    thermistor_adc_to_temperature_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic longint log2_fixed(input longint unsigned x);
        int              msb;
        longint unsigned mant;
        longint          frac;
        msb = 31;
        frac = 0;
        if (x == 0)
            return 0;
        while (msb > 0 && x[msb] == 1'b0)
            msb--;
        mant = x << (31 - msb);
        for (int i = 15; i >= 0; i--)
        begin
            mant = (mant * mant) >> 31;
            if (mant >= 64'h1_0000_0000)
            begin
                mant = mant >> 1;
                frac = frac | (64'sd1 << i);
            end
        end
        return longint'(msb) * 65536 + frac;
    endfunction

    function automatic temp_result_t predict_temperature(input logic [9:0] sample);
        temp_result_t r;
        longint       b, t0, r0, l2, ln_q32, inv, tk, t, v, q;
        longint       inv_num;
        inv_num = 100 * (64'sd1 << 40);
        b  = (beta_reg == 0) ? 1 : longint'(beta_reg);
        t0 = (t0_reg == 0) ? 1 : longint'(t0_reg);
        r0 = (r0_reg == 0) ? 1 : longint'(r0_reg);
        r.status = ST_OK;
        if (sample == 0)
        begin
            r.temp = OUT_MAX;
            r.status = ST_ZERO;
            return r;
        end
        if (sample >= ADC_FULL_SCALE || balance_reg == 0)
        begin
            r.temp = OUT_MAX;
            r.status = ST_SAT;
            return r;
        end
        l2 = log2_fixed(balance_reg) + log2_fixed(ADC_FULL_SCALE - sample)
           - log2_fixed(sample) - log2_fixed(r0);
        ln_q32 = l2 * 45426;
        inv = inv_num / t0 + (ln_q32 * 256) / b;
        if (inv <= 0)
        begin
            r.temp = OUT_MAX;
            r.status = ST_SAT;
            return r;
        end
        tk = (inv_num + inv / 2) / inv;
        if (unit_reg == UNIT_C)
            t = tk - 27315;
        else if (unit_reg == UNIT_F)
        begin
            v = 9 * (tk - 27315);
            q = (v >= 0) ? (v + 2) / 5 : -((-v + 2) / 5);
            t = q + 3200;
        end
        else
            t = tk;
        if (t > 200000)
        begin
            t = 200000;
            r.status = ST_SAT;
        end
        else if (t < -100000)
        begin
            t = -100000;
            r.status = ST_SAT;
        end
        r.temp = t[18:0];
        return r;
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end
        else if (!s_tvalid || in_taken)
        begin
            if (sample_queue.size() > 0 && $urandom_range(99, 0) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= {6'd0, sample_queue.pop_front()};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_off_cycles <= 0;
            hold_off_done <= 1'b0;
        end
        else if (hold_off_req && !hold_off_done)
        begin
            m_tready <= 1'b0;
            hold_off_cycles <= 399;
            hold_off_done <= 1'b1;
        end
        else if (hold_off_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        temp_result_t got;
        temp_result_t want;
        in_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
            expected_temps.push_back(predict_temperature(s_tdata[9:0]));
        if (rst_n && m_tvalid && m_tready)
        begin
            got.temp = m_tdata[18:0];
            got.status = m_tdata[20:19];
            if (expected_temps.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result: temp %0d status %0d",
                             got.temp, got.status);
            end
            else
            begin
                want = expected_temps.pop_front();
                if (got.temp !== want.temp || got.status !== want.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Result mismatch: expected temp %0d status %0d, got %0d %0d",
                                 want.temp, want.status, got.temp, got.status);
                end
            end
        end
    end

    task automatic write_register(input logic [2:0] idx, input logic [23:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_BETA:    beta_reg = value[15:0];
            CFG_T0:      t0_reg = value[15:0];
            CFG_R0:      r0_reg = value;
            CFG_BALANCE: balance_reg = value;
            CFG_UNIT:    unit_reg = value[1:0];
            default:     ;
        endcase
    endtask

    task automatic wait_drained();
        while (sample_queue.size() > 0 || s_tvalid || expected_temps.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic queue_samples(input int count);
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(9, 0))
                0:       sample_queue.push_back(10'($urandom_range(3, 0)));
                1:       sample_queue.push_back(10'($urandom_range(1023, 1019)));
                default: sample_queue.push_back(10'($urandom));
            endcase
        end
    endtask

    task automatic random_settings();
        write_register(CFG_BETA, 24'($urandom_range(65535, 1000)));
        write_register(CFG_T0, 24'($urandom_range(35000, 20000)));
        write_register(CFG_R0, 24'($urandom_range(200000, 100)));
        write_register(CFG_BALANCE, 24'($urandom_range(200000, 100)));
        write_register(CFG_UNIT, 24'($urandom_range(3, 0)));
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_req = 1'b0;
        beta_reg = 16'd4300;
        t0_reg = 16'd29815;
        r0_reg = 24'd10000;
        balance_reg = 24'd10000;
        unit_reg = UNIT_C;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        sample_queue.push_back(10'd0);
        sample_queue.push_back(10'd1);
        sample_queue.push_back(10'd2);
        sample_queue.push_back(10'd512);
        sample_queue.push_back(10'd1022);
        sample_queue.push_back(10'd1023);
        sample_queue.push_back(10'h155);
        sample_queue.push_back(10'h2AA);
        wait_drained();

        for (int u = 0; u < 4; u++)
        begin
            write_register(CFG_UNIT, 24'(u));
            sample_queue.push_back(10'd1);
            sample_queue.push_back(10'd300);
            sample_queue.push_back(10'd1023);
            wait_drained();
        end

        write_register(CFG_BETA, 24'd0);
        write_register(CFG_T0, 24'd0);
        write_register(CFG_R0, 24'd0);
        write_register(CFG_BALANCE, 24'd0);
        write_register(CFG_UNIT, 24'(UNIT_K));
        write_register(3'd7, 24'hFFFFFF);
        sample_queue.push_back(10'd5);
        wait_drained();

        write_register(CFG_BETA, 24'd65535);
        write_register(CFG_T0, 24'd65535);
        write_register(CFG_R0, 24'hFFFFFF);
        write_register(CFG_BALANCE, 24'hFFFFFF);
        write_register(CFG_UNIT, 24'(UNIT_F));
        sample_queue.push_back(10'd1);
        sample_queue.push_back(10'd700);
        wait_drained();
        write_register(CFG_BETA, 24'd1);
        sample_queue.push_back(10'd1);
        sample_queue.push_back(10'd1000);
        wait_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            random_settings();
            send_idle_pct = (phase == 1 || phase == 3) ? 74 : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? 74 : 0;
            if (phase == 3)
            begin
                send_idle_pct = 8;
                recv_stall_pct = 8;
            end
            if (phase == 0)
                hold_off_req = 1'b1;
            queue_samples(200);
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #400000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/tatu_pkg.sv
hdl/tatu_log4.sv
hdl/tatu_div.sv
hdl/tatu_conv.sv
hdl/thermistor_adc_to_temperature_unit.sv
hdl/tatu_chk.sv
tb/tb_thermistor_adc_to_temperature_unit.sv
